### hdl/bmpdec_pkg.sv
// Shared types and constants for the 24 bpp BMP to RGB565 decoder.
// Holds the byte and result word structs, the phase enum and the header
// offsets. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmpdec_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_value;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [1:0]  error_code;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } push_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE,
        PH_FAILED
    } phase_t;

    localparam logic [1:0] KIND_PIXEL    = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] ERR_SIGNATURE = 2'd0;
    localparam logic [1:0] ERR_HEADER    = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    localparam logic [7:0]  SIG_B       = 8'h42;
    localparam logic [7:0]  SIG_M       = 8'h4D;
    localparam logic [5:0]  OFF_SIG_B   = 6'd0;
    localparam logic [5:0]  OFF_SIG_M   = 6'd1;
    localparam logic [5:0]  OFF_WIDTH   = 6'd18;
    localparam logic [5:0]  OFF_HEIGHT  = 6'd22;
    localparam logic [5:0]  OFF_DEPTH   = 6'd28;
    localparam logic [5:0]  OFF_LAST    = 6'd53;
    localparam logic [15:0] DEPTH_24BPP = 16'd24;

    localparam out_word_t OUT_ZERO = '0;

endpackage

`default_nettype wire

### hdl/bmpdec_parser.sv
// Header parser, pixel converter and row bookkeeping for the BMP decoder.
// Turns one accepted byte into up to two result words. Uses bmpdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpdec_parser
    import bmpdec_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_word_t word,
    output push_t         push
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    phase_t            phase_reg, phase_next, phase_step;
    logic [5:0]        offset_reg, offset_next;
    logic [31:0]       width_reg, width_next;
    logic [31:0]       height_reg, height_next;
    logic [15:0]       depth_reg, depth_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [1:0]        trip_reg, trip_next;
    logic [1:0]        pad_reg, pad_next;
    logic [7:0]        blue_reg, blue_next;
    logic [7:0]        green_reg, green_next;

    logic [7:0]        b;
    logic              sig_bad;
    logic              hdr_end;
    logic              hdr_ok;
    logic              pix;
    logic              col_end;
    logic              row_end;
    logic              complete;
    logic              eof_err;
    logic              ev_main;
    logic [1:0]        sel;
    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  row_inc;
    logic [DIM_W-1:0]  row_top;
    out_word_t         main_word;
    out_word_t         done_word;
    out_word_t         trunc_word;

    assign b = word.data_byte;

    always_comb
    begin
        col_inc = col_reg + 1'b1;
        row_inc = row_reg + 1'b1;
        sig_bad = (phase_reg == PH_HEADER) &&
                  (((offset_reg == OFF_SIG_B) && (b != SIG_B)) ||
                   ((offset_reg == OFF_SIG_M) && (b != SIG_M)));
        hdr_end = (phase_reg == PH_HEADER) && !sig_bad && (offset_reg >= OFF_LAST);
        hdr_ok  = (width_reg != 32'd0) && (width_reg <= 32'(MAX_DIM)) &&
                  (height_reg != 32'd0) && (height_reg <= 32'(MAX_DIM)) &&
                  (depth_reg == DEPTH_24BPP);
        pix     = (phase_reg == PH_PIXEL) && (trip_reg == 2'd2);
        col_end = pix && (col_inc >= width_reg[DIM_W-1:0]);
        row_end = (col_end && (width_reg[1:0] == 2'd0)) ||
                  ((phase_reg == PH_PAD) && (pad_reg == 2'd1));
        complete = row_end && (row_inc >= height_reg[DIM_W-1:0]);
        row_top  = height_reg[DIM_W-1:0] - 1'b1 - row_reg;
    end

    always_comb
    begin
        phase_step = phase_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (sig_bad)
                    phase_step = PH_FAILED;
                else if (hdr_end)
                    phase_step = hdr_ok ? PH_PIXEL : PH_FAILED;
            end
            PH_PIXEL, PH_PAD:
            begin
                if (col_end && (width_reg[1:0] != 2'd0))
                    phase_step = PH_PAD;
                else if (row_end)
                    phase_step = complete ? PH_DONE : PH_PIXEL;
            end
            default:
                phase_step = phase_reg;
        endcase
        eof_err = word.end_of_file &&
                  ((phase_step == PH_HEADER) || (phase_step == PH_PIXEL) ||
                   (phase_step == PH_PAD));
        phase_next = phase_reg;
        if (fire)
            phase_next = word.end_of_file ? PH_HEADER : phase_step;
    end

    always_comb
    begin
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        trip_next   = trip_reg;
        pad_next    = pad_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        sel         = 2'(offset_reg - OFF_WIDTH);
        if (fire)
        begin
            if (word.end_of_file)
            begin
                offset_next = '0;
                width_next  = '0;
                height_next = '0;
                depth_next  = '0;
                col_next    = '0;
                row_next    = '0;
                trip_next   = '0;
                pad_next    = '0;
                blue_next   = '0;
                green_next  = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (!sig_bad)
                        begin
                            if ((offset_reg >= OFF_WIDTH) && (offset_reg < OFF_HEIGHT))
                            begin
                                sel = 2'(offset_reg - OFF_WIDTH);
                                width_next = width_reg | ({24'd0, b} << {sel, 3'b000});
                            end
                            else if ((offset_reg >= OFF_HEIGHT) &&
                                     (offset_reg < OFF_HEIGHT + 6'd4))
                            begin
                                sel = 2'(offset_reg - OFF_HEIGHT);
                                height_next = height_reg | ({24'd0, b} << {sel, 3'b000});
                            end
                            else if (offset_reg == OFF_DEPTH)
                                depth_next = depth_reg | {8'd0, b};
                            else if (offset_reg == OFF_DEPTH + 6'd1)
                                depth_next = depth_reg | {b, 8'd0};
                            if (hdr_end)
                            begin
                                col_next  = '0;
                                row_next  = '0;
                                trip_next = '0;
                                pad_next  = '0;
                            end
                            else
                                offset_next = offset_reg + 6'd1;
                        end
                    end
                    PH_PIXEL:
                    begin
                        case (trip_reg)
                            2'd0:
                            begin
                                blue_next = b;
                                trip_next = 2'd1;
                            end
                            2'd1:
                            begin
                                green_next = b;
                                trip_next  = 2'd2;
                            end
                            default:
                            begin
                                trip_next = 2'd0;
                                col_next  = col_end ? '0 : col_inc;
                                if (col_end)
                                    pad_next = width_reg[1:0];
                                if (row_end)
                                    row_next = row_inc;
                            end
                        endcase
                    end
                    PH_PAD:
                    begin
                        pad_next = pad_reg - 2'd1;
                        if (row_end)
                            row_next = row_inc;
                    end
                    default:
                    begin
                        offset_next = offset_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        main_word  = OUT_ZERO;
        done_word  = OUT_ZERO;
        trunc_word = OUT_ZERO;
        ev_main    = sig_bad || (hdr_end && !hdr_ok) || pix;

        main_word.kind = KIND_ERROR;
        if (sig_bad)
            main_word.error_code = ERR_SIGNATURE;
        else if (hdr_end)
            main_word.error_code = ERR_HEADER;
        else
        begin
            main_word.kind        = KIND_PIXEL;
            main_word.pixel_value = {b[7:3], green_reg[7:2], blue_reg[7:3]};
            main_word.column      = 12'(col_reg);
            main_word.row         = 12'(row_top);
        end

        done_word.kind         = KIND_COMPLETE;
        done_word.image_width  = width_reg[12:0];
        done_word.image_height = height_reg[12:0];

        trunc_word.kind       = KIND_ERROR;
        trunc_word.error_code = ERR_TRUNCATED;

        push.count  = 2'd0;
        push.first  = OUT_ZERO;
        push.second = OUT_ZERO;
        if (fire)
        begin
            push.count = 2'({1'b0, ev_main} + {1'b0, complete} + {1'b0, eof_err});
            if (ev_main)
                push.first = main_word;
            else if (complete)
                push.first = done_word;
            else
                push.first = trunc_word;
            if (ev_main && complete)
                push.second = done_word;
            else
                push.second = trunc_word;
            if (push.count == 2'd2)
                push.second.last = 1'b1;
            else
                push.first.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            trip_reg   <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            trip_reg   <= trip_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bmpdec_result_fifo.sv
// Four-entry result queue that takes up to two words per cycle and hands
// out one per cycle while ready is high. Uses bmpdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpdec_result_fifo
    import bmpdec_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic       valid,
    input  wire logic  ready,
    output out_word_t  data
);

    out_word_t  mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign valid = (count_reg != 3'd0);
    assign room  = (count_reg <= 3'd2);
    assign data  = mem[rd_reg];
    assign pop   = valid && ready;

    always_comb
    begin
        wr_next    = wr_reg + push.count;
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_reg + 2'd1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bmp24_to_rgb565_decoder.sv
// Top level of the streaming 24 bpp BMP to RGB565 decoder.
// Instantiates bmpdec_parser and bmpdec_result_fifo; uses bmpdec_pkg.
//
// The decoder takes one file byte per cycle, checks the signature and the
// 54-byte header, and emits one RGB565 pixel word per BGR triplet with its
// column and top-down row, then an image complete word; errors end the file
// with an error word, and pixels before a truncation error must be dropped.
// Every byte is handled combinationally by the header and pixel counters,
// and its result words, none, one or two, are written to a four-entry
// queue that is read one word per cycle while res_ready is high. A byte is
// taken whenever the queue has two free entries, which gives one byte per
// cycle as long as the result side keeps up. A byte marked end of file
// returns the parser to its reset state for the next file.
`timescale 1ns / 1ps
`default_nettype none

module bmp24_to_rgb565_decoder
    import bmpdec_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_ready,
    input  wire in_word_t byte_word,
    output logic          res_valid,
    input  wire logic     res_ready,
    output out_word_t     res_word
);

    push_t push;
    logic  room;
    logic  fire;

    assign byte_ready = room;
    assign fire       = byte_valid && room;

    bmpdec_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .word  (byte_word),
        .push  (push)
    );

    bmpdec_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (res_valid),
        .ready (res_ready),
        .data  (res_word)
    );

endmodule

`default_nettype wire
